/* sv/vng_pkg.sv */
// Package for the vertex normal generator.
// Holds operation codes and the item and normalizer structs.
// Depends on nothing; used by every module of the block.
package vng_pkg;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_TRI   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // classified item held in the queue between front and back
  typedef struct packed {
    logic [1:0]         op;
    logic               idx_ok;  // vertex_index in range
    logic               tri_ok;  // all three corners in range
    logic [7:0]         i0;
    logic [7:0]         i1;
    logic [7:0]         i2;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
  } item_t;

  // request into the normalizer: one-cycle go with the raw vector
  typedef struct packed {
    logic               go;
    logic signed [34:0] cx;
    logic signed [34:0] cy;
    logic signed [34:0] cz;
  } norm_req_t;

  // normalizer answer: one-cycle done with the Q1.14 unit vector
  typedef struct packed {
    logic               done;
    logic               zero;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } norm_rsp_t;

endpackage

/* sv/vng_front.sv */
// Front end of the vertex normal generator: accepts items, range-checks
// indices and keeps them in a two-entry queue for the back end.
// Depends on vng_pkg.
module vng_front #(
  parameter int MAX_VERTICES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          operation,
  input  logic [7:0]          vertex_index,
  input  logic [7:0]          corner_b,
  input  logic [7:0]          corner_c,
  input  logic signed [15:0]  pos_x,
  input  logic signed [15:0]  pos_y,
  input  logic signed [15:0]  pos_z,
  output logic                busy,
  input  logic                pop,
  output vng_pkg::item_t      head,
  output logic                head_valid
);

  vng_pkg::item_t fifo [2];
  vng_pkg::item_t incoming;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           do_pop;
  logic           ok0, ok1, ok2;

  // classify the incoming item
  always_comb begin
    ok0 = {24'd0, vertex_index} < 32'(MAX_VERTICES);
    ok1 = {24'd0, corner_b} < 32'(MAX_VERTICES);
    ok2 = {24'd0, corner_c} < 32'(MAX_VERTICES);
    incoming.op     = operation;
    incoming.idx_ok = ok0;
    incoming.tri_ok = ok0 & ok1 & ok2;
    incoming.i0     = vertex_index;
    incoming.i1     = corner_b;
    incoming.i2     = corner_c;
    incoming.px     = pos_x;
    incoming.py     = pos_y;
    incoming.pz     = pos_z;
  end

  assign busy       = (count == 2'd2);
  assign push       = start & ~busy;
  assign head_valid = (count != 2'd0);
  assign do_pop     = pop & head_valid;
  assign head       = fifo[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= incoming;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(do_pop);
    end
  end

endmodule

/* sv/vng_norm.sv */
// Iterative normalizer: scales a signed vector to a Q1.14 unit vector.
// Bit-serial square root (one result bit a cycle) and three restoring
// dividers in parallel (one quotient bit a cycle). Depends on vng_pkg.
module vng_norm (
  input  logic                clk,
  input  logic                rst,
  input  vng_pkg::norm_req_t  req,
  output vng_pkg::norm_rsp_t  rsp
);

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_MAG  = 3'd1;
  localparam logic [2:0] N_SQ   = 3'd2;
  localparam logic [2:0] N_SQRT = 3'd3;
  localparam logic [2:0] N_LEN  = 3'd4;
  localparam logic [2:0] N_DIV  = 3'd5;
  localparam logic [2:0] N_DONE = 3'd6;

  logic [2:0]         state;
  logic [4:0]         cnt;
  logic signed [34:0] c [3];
  logic [2:0]         sgn;
  logic [29:0]        mag [3];
  logic [61:0]        sum;
  logic [61:0]        nrem;
  logic [62:0]        res;
  logic [32:0]        dvs;
  logic [46:0]        rem [3];
  logic [14:0]        q [3];
  logic               zero;

  logic [34:0]        m [3];
  logic [34:0]        mx;
  logic [2:0]         sh;
  logic [59:0]        sq;
  logic [62:0]        bitv;
  logic [62:0]        trial;
  logic [46:0]        dk;

  // magnitudes, largest one and the right shift that fits it in 30 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i][34] ? 35'(-c[i]) : 35'(c[i]);
    end
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx[34])      sh = 3'd5;
    else if (mx[33]) sh = 3'd4;
    else if (mx[32]) sh = 3'd3;
    else if (mx[31]) sh = 3'd2;
    else if (mx[30]) sh = 3'd1;
    else             sh = 3'd0;
  end

  // square of one magnitude, sqrt trial value, divisor step
  always_comb begin
    sq    = 60'(mag[cnt[1:0]]) * 60'(mag[cnt[1:0]]);
    bitv  = 63'(1) << (6'd62 - {cnt, 1'b0});
    trial = res + bitv;
    dk    = 47'(dvs) << cnt[3:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        N_IDLE: begin
          if (req.go) state <= N_MAG;
        end
        N_MAG: begin
          state <= N_SQ;
          cnt   <= '0;
        end
        N_SQ: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd2) begin
            state <= N_SQRT;
            cnt   <= '0;
          end
        end
        N_SQRT: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= N_LEN;
        end
        N_LEN: begin
          cnt   <= 5'd14;
          state <= (res == '0) ? N_DONE : N_DIV;
        end
        N_DIV: begin
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) state <= N_DONE;
        end
        N_DONE: begin
          state <= N_IDLE;
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        if (req.go) begin
          c[0] <= req.cx;
          c[1] <= req.cy;
          c[2] <= req.cz;
          sum  <= '0;
          res  <= '0;
          zero <= 1'b0;
          for (int i = 0; i < 3; i++) q[i] <= '0;
        end
      end
      N_MAG: begin
        for (int i = 0; i < 3; i++) begin
          sgn[i] <= c[i][34];
          mag[i] <= 30'(m[i] >> sh);
        end
      end
      N_SQ: begin
        sum  <= sum + 62'(sq);
        nrem <= sum + 62'(sq);
      end
      N_SQRT: begin
        if ({1'b0, nrem} >= trial) begin
          nrem <= 62'({1'b0, nrem} - trial);
          res  <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
      end
      N_LEN: begin
        zero <= (res == '0);
        dvs  <= {res[31:0], 1'b0};
        for (int i = 0; i < 3; i++) begin
          rem[i] <= {2'b00, mag[i], 15'd0} + 47'(res[31:0]);
        end
      end
      N_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (rem[i] >= dk) begin
            rem[i] <= rem[i] - dk;
            q[i]   <= {q[i][13:0], 1'b1};
          end else begin
            q[i] <= {q[i][13:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // answer, valid in the done state only
  always_comb begin
    rsp.done = (state == N_DONE);
    rsp.zero = zero;
    rsp.nx   = sgn[0] ? -$signed({1'b0, q[0]}) : $signed({1'b0, q[0]});
    rsp.ny   = sgn[1] ? -$signed({1'b0, q[1]}) : $signed({1'b0, q[1]});
    rsp.nz   = sgn[2] ? -$signed({1'b0, q[2]}) : $signed({1'b0, q[2]});
  end

endmodule

/* sv/vng_back.sv */
// Back end of the vertex normal generator: position and accumulator
// memories, cross product on a shared multiplier, accumulator updates.
// Depends on vng_pkg; drives vng_norm through its request struct.
module vng_back #(
  parameter int MAX_VERTICES = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  vng_pkg::item_t      head,
  input  logic                head_valid,
  output logic                pop,
  output vng_pkg::norm_req_t  nreq,
  input  vng_pkg::norm_rsp_t  nrsp,
  output logic                done,
  output logic signed [15:0]  normal_x,
  output logic signed [15:0]  normal_y,
  output logic signed [15:0]  normal_z,
  output logic                zero_normal
);

  localparam int DEPTH = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_FETCH = 4'd1;
  localparam logic [3:0] B_DIFF  = 4'd2;
  localparam logic [3:0] B_MUL   = 4'd3;
  localparam logic [3:0] B_CROSS = 4'd4;
  localparam logic [3:0] B_NWAIT = 4'd5;
  localparam logic [3:0] B_ACC   = 4'd6;
  localparam logic [3:0] B_RDACC = 4'd7;
  localparam logic [3:0] B_RDCAP = 4'd8;

  logic [3:0]         state;
  logic [2:0]         cnt;
  vng_pkg::item_t     cur;

  logic [47:0]        pos_mem [DEPTH];
  logic [47:0]        pos_q;
  logic [AW-1:0]      pos_addr;
  logic [71:0]        acc_mem [DEPTH];
  logic [71:0]        acc_q;
  logic [AW-1:0]      acc_addr;
  logic [DEPTH-1:0]   valid;

  logic [47:0]        p0, p1, p2;
  logic signed [16:0] ax, ay, az, bx, by, bz;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] pr [6];
  logic signed [15:0] nx, ny, nz;

  logic               acc_write;
  logic [71:0]        acc_new;
  logic [23:0]        base_x, base_y, base_z;
  logic               pop_write;

  function automatic logic [23:0] sat_add(input logic [23:0] a,
                                          input logic signed [15:0] b);
    logic [24:0] s;
    s = {a[23], a} + {{9{b[15]}}, b};
    if (s[24] != s[23]) begin
      sat_add = s[24] ? 24'h800000 : 24'h7FFFFF;
    end else begin
      sat_add = s[23:0];
    end
  endfunction

  function automatic logic signed [34:0] sx24(input logic [23:0] v);
    sx24 = $signed({{11{v[23]}}, v});
  endfunction

  assign pop       = (state == B_IDLE) & head_valid;
  assign pop_write = pop & (head.op == vng_pkg::OP_WRITE) & head.idx_ok;

  // memory addresses
  always_comb begin
    case (cnt[1:0])
      2'd0:    pos_addr = cur.i0[AW-1:0];
      2'd1:    pos_addr = cur.i1[AW-1:0];
      default: pos_addr = cur.i2[AW-1:0];
    endcase
    if (state == B_ACC) begin
      case (cnt[2:1])
        2'd0:    acc_addr = cur.i0[AW-1:0];
        2'd1:    acc_addr = cur.i1[AW-1:0];
        default: acc_addr = cur.i2[AW-1:0];
      endcase
    end else begin
      acc_addr = cur.i0[AW-1:0];
    end
  end

  // accumulator read-modify-write value; a cleared entry starts at zero
  always_comb begin
    base_x    = valid[acc_addr] ? acc_q[71:48] : 24'd0;
    base_y    = valid[acc_addr] ? acc_q[47:24] : 24'd0;
    base_z    = valid[acc_addr] ? acc_q[23:0]  : 24'd0;
    acc_new   = {sat_add(base_x, nx), sat_add(base_y, ny), sat_add(base_z, nz)};
    acc_write = (state == B_ACC) & cnt[0];
  end

  // position memory
  always_ff @(posedge clk) begin
    if (pop_write) begin
      pos_mem[head.i0[AW-1:0]] <= {head.px, head.py, head.pz};
    end
    pos_q <= pos_mem[pos_addr];
  end

  // accumulator memory
  always_ff @(posedge clk) begin
    if (acc_write) begin
      acc_mem[acc_addr] <= acc_new;
    end
    acc_q <= acc_mem[acc_addr];
  end

  // shared multiplier operand select for the cross product
  always_comb begin
    case (cnt)
      3'd0:    begin mul_a = ay; mul_b = bz; end
      3'd1:    begin mul_a = az; mul_b = by; end
      3'd2:    begin mul_a = az; mul_b = bx; end
      3'd3:    begin mul_a = ax; mul_b = bz; end
      3'd4:    begin mul_a = ax; mul_b = by; end
      default: begin mul_a = ay; mul_b = bx; end
    endcase
  end

  // normalizer request: face normal after the cross, or a stored sum
  always_comb begin
    nreq.go = (state == B_CROSS) | (state == B_RDCAP);
    if (state == B_CROSS) begin
      nreq.cx = $signed({pr[0][33], pr[0]}) - $signed({pr[1][33], pr[1]});
      nreq.cy = $signed({pr[2][33], pr[2]}) - $signed({pr[3][33], pr[3]});
      nreq.cz = $signed({pr[4][33], pr[4]}) - $signed({pr[5][33], pr[5]});
    end else if (valid[cur.i0[AW-1:0]]) begin
      nreq.cx = sx24(acc_q[71:48]);
      nreq.cy = sx24(acc_q[47:24]);
      nreq.cz = sx24(acc_q[23:0]);
    end else begin
      nreq.cx = '0;
      nreq.cy = '0;
      nreq.cz = '0;
    end
  end

  // control: sequencer, valid bits and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      cnt   <= '0;
      valid <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_IDLE: begin
          cnt <= '0;
          if (pop) begin
            case (head.op)
              vng_pkg::OP_TRI: begin
                if (head.tri_ok) state <= B_FETCH;
              end
              vng_pkg::OP_READ: begin
                if (head.idx_ok) state <= B_RDACC;
                else done <= 1'b1;
              end
              vng_pkg::OP_CLEAR: valid <= '0;
              default: ;
            endcase
          end
        end
        B_FETCH: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) state <= B_DIFF;
        end
        B_DIFF: begin
          cnt   <= '0;
          state <= B_MUL;
        end
        B_MUL: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd5) state <= B_CROSS;
        end
        B_CROSS: state <= B_NWAIT;
        B_NWAIT: begin
          cnt <= '0;
          if (nrsp.done) begin
            if (cur.op == vng_pkg::OP_READ) begin
              done  <= 1'b1;
              state <= B_IDLE;
            end else begin
              state <= nrsp.zero ? B_IDLE : B_ACC;
            end
          end
        end
        B_ACC: begin
          cnt <= cnt + 3'd1;
          if (cnt[0]) valid[acc_addr] <= 1'b1;
          if (cnt == 3'd5) state <= B_IDLE;
        end
        B_RDACC: state <= B_RDCAP;
        B_RDCAP: state <= B_NWAIT;
        default: state <= B_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) cur <= head;
    if (state == B_FETCH) begin
      case (cnt[1:0])
        2'd1:    p0 <= pos_q;
        2'd2:    p1 <= pos_q;
        2'd3:    p2 <= pos_q;
        default: ;
      endcase
    end
    if (state == B_DIFF) begin
      ax <= $signed({p1[47], p1[47:32]}) - $signed({p0[47], p0[47:32]});
      ay <= $signed({p1[31], p1[31:16]}) - $signed({p0[31], p0[31:16]});
      az <= $signed({p1[15], p1[15:0]})  - $signed({p0[15], p0[15:0]});
      bx <= $signed({p0[47], p0[47:32]}) - $signed({p2[47], p2[47:32]});
      by <= $signed({p0[31], p0[31:16]}) - $signed({p2[31], p2[31:16]});
      bz <= $signed({p0[15], p0[15:0]})  - $signed({p2[15], p2[15:0]});
    end
    if (state == B_MUL) begin
      pr[cnt] <= mul_a * mul_b;
    end
    if (state == B_NWAIT && nrsp.done) begin
      nx <= nrsp.nx;
      ny <= nrsp.ny;
      nz <= nrsp.nz;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == B_IDLE) begin
      normal_x    <= '0;
      normal_y    <= '0;
      normal_z    <= '0;
      zero_normal <= 1'b1;
    end else if (state == B_NWAIT && nrsp.done) begin
      normal_x    <= nrsp.nx;
      normal_y    <= nrsp.ny;
      normal_z    <= nrsp.nz;
      zero_normal <= nrsp.zero;
    end
  end

endmodule

/* sv/vertex_normal_generator_core.sv */
// Vertex normal generator: smooth per-vertex normals from face normals.
//
// Command port: an item is taken at a rising edge with start high and busy
// low. operation selects write position, add triangle, read normal or clear.
// Items go into a two-entry queue; busy is high while the queue is full.
// A read answers with one result on normal_x/y/z and zero_normal, shown for
// exactly one cycle with done high. Writes, triangles and clears answer
// nothing. The receiver cannot stall; results are never held back.
// In the back end a write or a clear completes as it is dequeued. A triangle
// runs position fetch, six products on one 17x17 multiplier, a bit-serial
// square root and restoring division, then three read-modify-write
// accumulator updates; a degenerate face skips the division and the updates.
// A read fetches the stored sum and normalizes it; a zero sum skips the
// division. The back end takes the next item only when back in idle.
// Out-of-range reads answer at once with a zero vector and zero_normal set.
// Reset empties the queue and marks every accumulator cleared at once;
// positions are undefined until written.
// Depends on vng_pkg, vng_front, vng_norm, vng_back.
module vertex_normal_generator_core #(
  parameter int MAX_VERTICES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [7:0]         vertex_index,
  input  logic [7:0]         corner_b,
  input  logic [7:0]         corner_c,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  output logic               done,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  output logic               zero_normal
);

  vng_pkg::item_t     head;
  logic               head_valid;
  logic               pop;
  vng_pkg::norm_req_t nreq;
  vng_pkg::norm_rsp_t nrsp;

  vng_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .operation    (operation),
    .vertex_index (vertex_index),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .busy         (busy),
    .pop          (pop),
    .head         (head),
    .head_valid   (head_valid)
  );

  vng_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (nreq),
    .rsp (nrsp)
  );

  vng_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .nreq        (nreq),
    .nrsp        (nrsp),
    .done        (done),
    .normal_x    (normal_x),
    .normal_y    (normal_y),
    .normal_z    (normal_z),
    .zero_normal (zero_normal)
  );

endmodule

/* dv/vertex_normal_generator_core_tb.sv */
// Testbench for vertex_normal_generator_core: directed and random items with
// a built-in predictor of positions, saturating accumulators and normalization.
// Depends on vng_pkg and the vertex_normal_generator_core RTL.
`timescale 1ns / 100ps

module vertex_normal_generator_core_tb;

  typedef struct {
    logic [1:0]         op;
    logic [7:0]         i0;
    logic [7:0]         i1;
    logic [7:0]         i2;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] pz;
    int                 gap;
    bit                 drain;  // hold this item until all reads have answered
  } cmd_t;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               zero;
  } unit_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [1:0]         operation;
  logic [7:0]         vertex_index;
  logic [7:0]         corner_b;
  logic [7:0]         corner_c;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic               done;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic               zero_normal;

  cmd_t  pending_cmds[$];
  unit_t expected_normals[$];
  int    error_count = 0;
  int    reads_checked = 0;
  int    tris_sent = 0;
  int    clears_sent = 0;

  // predictor state
  logic signed [15:0] pos_mem[256][3];
  int                 acc_mem[256][3];
  bit                 acc_live[256];
  bit                 gen_written[256];
  int                 gen_pool[$];

  vertex_normal_generator_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .vertex_index(vertex_index),
    .corner_b(corner_b), .corner_c(corner_c),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .done(done), .normal_x(normal_x), .normal_y(normal_y),
    .normal_z(normal_z), .zero_normal(zero_normal)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // bitwise integer square root, floor
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // scale a vector to Q1.14 unit length, half-up rounding on magnitudes
  function automatic unit_t unit_vector(longint cx, longint cy, longint cz);
    longint          c[3];
    longint unsigned mag[3];
    longint unsigned mx;
    longint unsigned sum;
    longint unsigned len;
    longint unsigned q;
    int              s;
    unit_t           u;
    c[0] = cx; c[1] = cy; c[2] = cz;
    mx = 0;
    sum = 0;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = (c[k] < 0) ? -c[k] : c[k];
      if (mag[k] > mx) mx = mag[k];
    end
    while (s < 63 && (mx >> s) >= (64'd1 << 30)) s++;
    for (int k = 0; k < 3; k++) begin
      mag[k] >>= s;
      sum += mag[k] * mag[k];
    end
    len = isqrt(sum);
    u = '{nx: 16'sd0, ny: 16'sd0, nz: 16'sd0, zero: 1'b1};
    if (len != 0) begin
      u.zero = 1'b0;
      q = (mag[0] * 32768 + len) / (2 * len);
      u.nx = (c[0] < 0) ? -q[15:0] : q[15:0];
      q = (mag[1] * 32768 + len) / (2 * len);
      u.ny = (c[1] < 0) ? -q[15:0] : q[15:0];
      q = (mag[2] * 32768 + len) / (2 * len);
      u.nz = (c[2] < 0) ? -q[15:0] : q[15:0];
    end
    return u;
  endfunction

  function automatic int sat24(int a, int b);
    longint r;
    r = longint'(a) + longint'(b);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return int'(r);
  endfunction

  // update the predicted state for one accepted item; queue a read's answer
  task automatic predict_item(cmd_t c);
    longint ea[3];
    longint eb[3];
    int     idx[3];
    int     n[3];
    unit_t  u;
    case (c.op)
      vng_pkg::OP_WRITE: begin
        pos_mem[c.i0][0] = c.px;
        pos_mem[c.i0][1] = c.py;
        pos_mem[c.i0][2] = c.pz;
      end
      vng_pkg::OP_TRI: begin
        tris_sent++;
        for (int k = 0; k < 3; k++) begin
          ea[k] = longint'(pos_mem[c.i1][k]) - longint'(pos_mem[c.i0][k]);
          eb[k] = longint'(pos_mem[c.i0][k]) - longint'(pos_mem[c.i2][k]);
        end
        u = unit_vector(ea[1] * eb[2] - ea[2] * eb[1],
                        ea[2] * eb[0] - ea[0] * eb[2],
                        ea[0] * eb[1] - ea[1] * eb[0]);
        if (!u.zero) begin
          idx[0] = c.i0; idx[1] = c.i1; idx[2] = c.i2;
          n[0] = u.nx; n[1] = u.ny; n[2] = u.nz;
          for (int v = 0; v < 3; v++) begin
            if (!acc_live[idx[v]]) begin
              acc_mem[idx[v]] = '{0, 0, 0};
              acc_live[idx[v]] = 1'b1;
            end
            for (int k = 0; k < 3; k++)
              acc_mem[idx[v]][k] = sat24(acc_mem[idx[v]][k], n[k]);
          end
        end
      end
      vng_pkg::OP_CLEAR: begin
        clears_sent++;
        acc_live = '{default: 1'b0};
      end
      default: begin
        if (acc_live[c.i0])
          u = unit_vector(acc_mem[c.i0][0], acc_mem[c.i0][1], acc_mem[c.i0][2]);
        else
          u = unit_vector(0, 0, 0);
        expected_normals.insert(expected_normals.size(), u);
      end
    endcase
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // queue builders
  task automatic push_cmd(logic [1:0] op, int a, int b, int c, int x, int y, int z,
                          bit drain = 0);
    cmd_t cm;
    cm.op = op; cm.i0 = a[7:0]; cm.i1 = b[7:0]; cm.i2 = c[7:0];
    cm.px = x[15:0]; cm.py = y[15:0]; cm.pz = z[15:0];
    cm.gap = $urandom_range(0, 19);
    cm.drain = drain;
    if (op == vng_pkg::OP_WRITE && !gen_written[a[7:0]]) begin
      gen_written[a[7:0]] = 1'b1;
      gen_pool.insert(gen_pool.size(), int'(a[7:0]));
    end
    pending_cmds.insert(pending_cmds.size(), cm);
  endtask

  // driver: start stays high until the item is taken
  int hold_cnt = 0;
  always @(posedge clk) begin
    cmd_t nxt;
    bit   fire;
    if (rst) begin
      start <= 1'b0;
      hold_cnt = 0;
    end else begin
      fire = start && !busy;
      if (fire) predict_item('{operation, vertex_index, corner_b, corner_c,
                                pos_x, pos_y, pos_z, 0, 1'b0});
      if (!start || fire) begin
        if (pending_cmds.size() == 0) begin
          start <= 1'b0;
        end else if (hold_cnt < pending_cmds[0].gap) begin
          hold_cnt++;
          start <= 1'b0;
        end else if (pending_cmds[0].drain && expected_normals.size() != 0) begin
          start <= 1'b0;
        end else begin
          nxt = pending_cmds.pop_front();
          hold_cnt = 0;
          start <= 1'b1;
          operation <= nxt.op;
          vertex_index <= nxt.i0;
          corner_b <= nxt.i1;
          corner_c <= nxt.i2;
          pos_x <= nxt.px;
          pos_y <= nxt.py;
          pos_z <= nxt.pz;
        end
      end
    end
  end

  // monitor: every done pulse is one read answer
  always @(posedge clk) begin
    unit_t w;
    if (!rst && done) begin
      if (expected_normals.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        w = expected_normals.pop_front();
        reads_checked++;
        if (normal_x !== w.nx) report_mismatch("normal_x", normal_x, w.nx);
        if (normal_y !== w.ny) report_mismatch("normal_y", normal_y, w.ny);
        if (normal_z !== w.nz) report_mismatch("normal_z", normal_z, w.nz);
        if (zero_normal !== w.zero) report_mismatch("zero_normal", zero_normal, w.zero);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int  r;
    int  a;
    bit  calm;
    start = 1'b0;
    operation = vng_pkg::OP_WRITE;
    vertex_index = '0;
    corner_b = '0;
    corner_c = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    acc_live = '{default: 1'b0};
    gen_written = '{default: 1'b0};
    rst = 1'b1;

    // directed: extreme positions, plain, large and degenerate triangles
    push_cmd(vng_pkg::OP_WRITE, 0, 0, 0, 0, 0, 0);
    push_cmd(vng_pkg::OP_WRITE, 1, 255, 255, 32767, 0, 0);
    push_cmd(vng_pkg::OP_WRITE, 2, 0, 0, 0, 32767, 0);
    push_cmd(vng_pkg::OP_WRITE, 3, 0, 0, -32768, -32768, -32768);
    push_cmd(vng_pkg::OP_WRITE, 4, 0, 0, 32767, 32767, 32767);
    push_cmd(vng_pkg::OP_WRITE, 5, 0, 0, -16384, -16384, -16384);
    push_cmd(vng_pkg::OP_WRITE, 255, 0, 0, -1, -1, -1);
    push_cmd(vng_pkg::OP_READ, 0, 0, 0, 0, 0, 0);        // never accumulated
    push_cmd(vng_pkg::OP_TRI, 0, 1, 2, 0, 0, 0);
    push_cmd(vng_pkg::OP_TRI, 3, 4, 1, 0, 0, 0);
    push_cmd(vng_pkg::OP_TRI, 0, 0, 1, 0, 0, 0);         // repeated corner
    push_cmd(vng_pkg::OP_TRI, 0, 3, 5, 0, 0, 0);         // collinear corners
    push_cmd(vng_pkg::OP_TRI, 255, 3, 2, 0, 0, 0);
    push_cmd(vng_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    push_cmd(vng_pkg::OP_READ, 1, 0, 0, 0, 0, 0);
    push_cmd(vng_pkg::OP_READ, 3, 0, 0, 0, 0, 0);
    push_cmd(vng_pkg::OP_READ, 255, 0, 0, 0, 0, 0);
    push_cmd(vng_pkg::OP_READ, 200, 255, 255, -32768, 32767, -32768);
    push_cmd(vng_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0, 1);
    push_cmd(vng_pkg::OP_READ, 0, 0, 0, 0, 0, 0);
    push_cmd(vng_pkg::OP_TRI, 0, 1, 2, 0, 0, 0);
    push_cmd(vng_pkg::OP_READ, 2, 0, 0, 0, 0, 0);

    // drive the accumulators of one triangle's three corners into saturation
    for (int k = 0; k < 520; k++) begin
      push_cmd(vng_pkg::OP_TRI, 0, 1, 2, 0, 0, 0);
      pending_cmds[$].gap = 0;
    end
    push_cmd(vng_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 1);
    push_cmd(vng_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0);

    // random mix, mostly triangles over written vertices
    calm = 0;
    for (int k = 0; k < 360; k++) begin
      if (k % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      a = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 255);
      if (r < 20)
        push_cmd(vng_pkg::OP_WRITE, a, $urandom, $urandom, $urandom, $urandom, $urandom);
      else if (r < 70)
        push_cmd(vng_pkg::OP_TRI, gen_pool[$urandom_range(0, gen_pool.size() - 1)],
                 gen_pool[$urandom_range(0, gen_pool.size() - 1)],
                 gen_pool[$urandom_range(0, gen_pool.size() - 1)],
                 $urandom, $urandom, $urandom);
      else if (r < 95)
        push_cmd(vng_pkg::OP_READ, a, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(0, 99) == 0);
      else
        push_cmd(vng_pkg::OP_CLEAR, a, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (calm) pending_cmds[$].gap = 0;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (pending_cmds.size() == 0);
    @(posedge clk);
    wait (start == 1'b0);
    wait (expected_normals.size() == 0);
    repeat (200) @(posedge clk);

    $display("Covered %0d triangles, %0d clears and %0d checked reads,",
             tris_sent, clears_sent, reads_checked);
    $display("including degenerate faces and saturated accumulators.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
